### src/fplst_pkg.sv
// Shared types and constants for the far point pair lister.
`timescale 1ns / 1ps

package fplst_pkg;

  localparam int unsigned MAX_POINTS_DEF = 16;
  localparam int unsigned IDX_W          = 4;
  localparam int unsigned COORD_W        = 8;
  localparam int unsigned DIST_W         = 17;
  localparam int unsigned SQ_W           = 18;

  typedef enum logic [1:0] {
    RES_OK         = 2'd0,
    RES_FULL       = 2'd1,
    RES_NOT_LOADED = 2'd2
  } fplst_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESP,
    ST_QLAT,
    ST_SCAN,
    ST_FIN
  } fplst_state_e;

  typedef enum logic [1:0] {
    OUT_SINGLE,
    OUT_PEND_MORE,
    OUT_PEND_LAST
  } fplst_out_kind_e;

  typedef struct packed {
    logic            accept;
    logic            q_latch;
    logic            scan_step;
    logic            out_load;
    fplst_out_kind_e out_kind;
    logic            set_drained;
  } fplst_cmd_t;

  typedef struct packed {
    logic query;
    logic q_bad;
    logic q_drained;
    logic match;
    logic pend_valid;
    logic j_zero;
    logic out_free;
  } fplst_stat_t;

endpackage

### src/far_point_pair_lister_core.sv
// Top level of the far point pair lister: controller, datapath and checks.
`timescale 1ns / 1ps

// Usage: the input channel (in_valid_i / in_ready_o) carries one beat per item.
// mode_i 0 loads the point (x_coord_i, y_coord_i) at the next free index;
// mode_i 1 asks for every other loaded point whose squared distance to point
// query_index_i reaches the threshold, listed from the highest index down.
// Each item produces one or more result beats on the output channel
// (out_valid_o / out_ready_i); last_o marks the final beat of an item.
// A load, a rejected query or a query of a drained point passes through the
// response state, which loads its result once the output register is free.
// A query that scans reads the stored points one per cycle while the scan is
// not halted, through the single read port of the point memory, and the final
// beat is ready after the scan. The threshold is written through cfg_we_i /
// cfg_wdata_i while idle. A stalled receiver holds the output register; the
// scan halts when it finds a partner while the output register and the one
// pending partner are both occupied, and the input stays not ready until the
// final beat is loaded. Reset empties the store, clears the drained flags
// and the threshold, and drops any pending output beat.
module far_point_pair_lister_core #(
  parameter int unsigned MaxPoints = fplst_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  input  logic signed [fplst_pkg::COORD_W-1:0] x_coord_i,
  input  logic signed [fplst_pkg::COORD_W-1:0] y_coord_i,
  input  logic [fplst_pkg::IDX_W-1:0]         query_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [fplst_pkg::IDX_W-1:0]         partner_index_o,
  output logic                                has_partner_o,
  output logic [1:0]                          status_o,
  output logic                                last_o,
  input  logic                                cfg_we_i,
  input  logic [fplst_pkg::DIST_W-1:0]        cfg_wdata_i
);

  fplst_pkg::fplst_cmd_t  cmd;
  fplst_pkg::fplst_stat_t stat;

  fplst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fplst_dp #(
    .MaxPoints (MaxPoints)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (mode_i),
    .x_coord_i       (x_coord_i),
    .y_coord_i       (y_coord_i),
    .query_index_i   (query_index_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .partner_index_o (partner_index_o),
    .has_partner_o   (has_partner_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  // A beat that is not the last of its item always names a partner.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> has_partner_o)
    else $error("non-final beat without a partner");

  // A beat without a partner carries index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_partner_o) |-> (partner_index_o == '0))
    else $error("partner index set on an empty beat");

  // Error statuses come only on single closing beats without a partner.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != fplst_pkg::RES_OK)) |-> (last_o && !has_partner_o))
    else $error("error status on a partner beat");

  // New items are taken only when no output beat is being produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !cmd.out_load)
    else $error("item accepted while an output beat is loaded");

endmodule

### src/fplst_ctrl.sv
// Controller state machine that sequences loads, queries and the partner scan.
`timescale 1ns / 1ps

module fplst_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fplst_pkg::fplst_stat_t stat_i,
  output fplst_pkg::fplst_cmd_t  cmd_o
);

  fplst_pkg::fplst_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fplst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fplst_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (!stat_i.query || stat_i.q_bad || stat_i.q_drained) begin
            state_d = fplst_pkg::ST_RESP;
          end else begin
            state_d = fplst_pkg::ST_QLAT;
          end
        end
      end
      fplst_pkg::ST_RESP: begin
        if (stat_i.out_free) begin
          state_d = fplst_pkg::ST_IDLE;
        end
      end
      fplst_pkg::ST_QLAT: begin
        state_d = fplst_pkg::ST_SCAN;
      end
      fplst_pkg::ST_SCAN: begin
        if (!(stat_i.match && stat_i.pend_valid && !stat_i.out_free) && stat_i.j_zero) begin
          state_d = fplst_pkg::ST_FIN;
        end
      end
      fplst_pkg::ST_FIN: begin
        if (stat_i.out_free) begin
          state_d = fplst_pkg::ST_IDLE;
        end
      end
      default: state_d = fplst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o             = '0;
    cmd_o.out_kind    = fplst_pkg::OUT_SINGLE;
    case (state_q)
      fplst_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      fplst_pkg::ST_RESP: begin
        cmd_o.out_load = stat_i.out_free;
      end
      fplst_pkg::ST_QLAT: begin
        cmd_o.q_latch = 1'b1;
      end
      fplst_pkg::ST_SCAN: begin
        cmd_o.scan_step = !(stat_i.match && stat_i.pend_valid && !stat_i.out_free);
        cmd_o.out_load  = cmd_o.scan_step && stat_i.match && stat_i.pend_valid;
        cmd_o.out_kind  = fplst_pkg::OUT_PEND_MORE;
      end
      fplst_pkg::ST_FIN: begin
        cmd_o.out_load    = stat_i.out_free;
        cmd_o.set_drained = stat_i.out_free;
        cmd_o.out_kind    = stat_i.pend_valid ? fplst_pkg::OUT_PEND_LAST
                                              : fplst_pkg::OUT_SINGLE;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### src/fplst_dp.sv
// Datapath: point memory, drained flags, distance unit and output register.
`timescale 1ns / 1ps

module fplst_dp #(
  parameter int unsigned MaxPoints = fplst_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                mode_i,
  input  logic signed [fplst_pkg::COORD_W-1:0] x_coord_i,
  input  logic signed [fplst_pkg::COORD_W-1:0] y_coord_i,
  input  logic [fplst_pkg::IDX_W-1:0]         query_index_i,
  input  logic                                cfg_we_i,
  input  logic [fplst_pkg::DIST_W-1:0]        cfg_wdata_i,
  input  fplst_pkg::fplst_cmd_t               cmd_i,
  output fplst_pkg::fplst_stat_t              stat_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [fplst_pkg::IDX_W-1:0]         partner_index_o,
  output logic                                has_partner_o,
  output logic [1:0]                          status_o,
  output logic                                last_o
);

  localparam int unsigned AW   = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CW   = $clog2(MaxPoints + 1);
  localparam int unsigned CmpW = ((CW > fplst_pkg::IDX_W) ? CW : fplst_pkg::IDX_W) + 1;

  logic [fplst_pkg::COORD_W-1:0] mem_x_q [MaxPoints];
  logic [fplst_pkg::COORD_W-1:0] mem_y_q [MaxPoints];
  logic [fplst_pkg::COORD_W-1:0] rd_x_q, rd_y_q;
  logic [AW-1:0]                 rd_addr;

  logic [CW-1:0]                 count_q, count_d;
  logic [MaxPoints-1:0]          drained_q, drained_d;
  logic [fplst_pkg::DIST_W-1:0]  dist_min_q, dist_min_d;
  fplst_pkg::fplst_status_e      resp_status_q, resp_status_d;
  logic [AW-1:0]                 q_idx_q, q_idx_d;
  logic [fplst_pkg::COORD_W-1:0] qx_q, qx_d, qy_q, qy_d;
  logic [AW-1:0]                 j_q, j_d;
  logic [AW-1:0]                 pend_q, pend_d;
  logic                          pend_valid_q, pend_valid_d;

  logic                          out_valid_q, out_valid_d;
  logic [fplst_pkg::IDX_W-1:0]   out_partner_q, out_partner_d;
  logic                          out_has_q, out_has_d;
  fplst_pkg::fplst_status_e      out_status_q, out_status_d;
  logic                          out_last_q, out_last_d;

  logic                          full;
  logic                          q_bad;
  logic [AW-1:0]                 q_addr;
  logic signed [fplst_pkg::COORD_W:0] dx, dy;
  logic signed [fplst_pkg::SQ_W-1:0]  dx2, dy2;
  logic [fplst_pkg::SQ_W-1:0]    dist_sq;
  logic                          match;
  logic                          out_free;

  assign full   = (count_q == CW'(MaxPoints));
  assign q_bad  = (CmpW'(query_index_i) >= CmpW'(count_q));
  assign q_addr = AW'(query_index_i);

  assign dx      = $signed({qx_q[fplst_pkg::COORD_W-1], qx_q})
                 - $signed({rd_x_q[fplst_pkg::COORD_W-1], rd_x_q});
  assign dy      = $signed({qy_q[fplst_pkg::COORD_W-1], qy_q})
                 - $signed({rd_y_q[fplst_pkg::COORD_W-1], rd_y_q});
  assign dx2     = dx * dx;
  assign dy2     = dy * dy;
  assign dist_sq = $unsigned(dx2) + $unsigned(dy2);
  assign match   = (j_q != q_idx_q) && (dist_sq >= {1'b0, dist_min_q});

  assign out_free = !out_valid_q || out_ready_i;

  assign stat_o.query      = mode_i;
  assign stat_o.q_bad      = q_bad;
  assign stat_o.q_drained  = q_bad ? 1'b0 : drained_q[q_addr];
  assign stat_o.match      = match;
  assign stat_o.pend_valid = pend_valid_q;
  assign stat_o.j_zero     = (j_q == '0);
  assign stat_o.out_free   = out_free;

  always_comb begin
    if (cmd_i.accept) begin
      rd_addr = q_addr;
    end else if (cmd_i.q_latch) begin
      rd_addr = AW'(count_q - CW'(1));
    end else if (cmd_i.scan_step && (j_q != '0)) begin
      rd_addr = j_q - AW'(1);
    end else begin
      rd_addr = j_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !mode_i && !full) begin
      mem_x_q[AW'(count_q)] <= x_coord_i;
      mem_y_q[AW'(count_q)] <= y_coord_i;
    end
    rd_x_q <= mem_x_q[rd_addr];
    rd_y_q <= mem_y_q[rd_addr];
  end

  always_comb begin
    count_d       = count_q;
    drained_d     = drained_q;
    dist_min_d    = cfg_we_i ? cfg_wdata_i : dist_min_q;
    resp_status_d = resp_status_q;
    q_idx_d       = q_idx_q;
    qx_d          = qx_q;
    qy_d          = qy_q;
    j_d           = j_q;
    pend_d        = pend_q;
    pend_valid_d  = pend_valid_q;

    if (cmd_i.accept) begin
      q_idx_d = q_addr;
      if (!mode_i) begin
        resp_status_d = full ? fplst_pkg::RES_FULL : fplst_pkg::RES_OK;
        if (!full) begin
          count_d = count_q + CW'(1);
        end
      end else begin
        resp_status_d = q_bad ? fplst_pkg::RES_NOT_LOADED : fplst_pkg::RES_OK;
      end
    end
    if (cmd_i.q_latch) begin
      qx_d         = rd_x_q;
      qy_d         = rd_y_q;
      j_d          = AW'(count_q - CW'(1));
      pend_valid_d = 1'b0;
    end
    if (cmd_i.scan_step) begin
      if (j_q != '0) begin
        j_d = j_q - AW'(1);
      end
      if (match) begin
        pend_d       = j_q;
        pend_valid_d = 1'b1;
      end
    end
    if (cmd_i.set_drained) begin
      drained_d[q_idx_q] = 1'b1;
    end
  end

  always_comb begin
    out_valid_d   = out_valid_q;
    out_partner_d = out_partner_q;
    out_has_d     = out_has_q;
    out_status_d  = out_status_q;
    out_last_d    = out_last_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      case (cmd_i.out_kind)
        fplst_pkg::OUT_SINGLE: begin
          out_partner_d = '0;
          out_has_d     = 1'b0;
          out_status_d  = resp_status_q;
          out_last_d    = 1'b1;
        end
        fplst_pkg::OUT_PEND_MORE: begin
          out_partner_d = fplst_pkg::IDX_W'(pend_q);
          out_has_d     = 1'b1;
          out_status_d  = fplst_pkg::RES_OK;
          out_last_d    = 1'b0;
        end
        fplst_pkg::OUT_PEND_LAST: begin
          out_partner_d = fplst_pkg::IDX_W'(pend_q);
          out_has_d     = 1'b1;
          out_status_d  = fplst_pkg::RES_OK;
          out_last_d    = 1'b1;
        end
        default: begin
          out_valid_d = 1'b0;
        end
      endcase
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      drained_q    <= '0;
      dist_min_q   <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      drained_q    <= drained_d;
      dist_min_q   <= dist_min_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    resp_status_q <= resp_status_d;
    q_idx_q       <= q_idx_d;
    qx_q          <= qx_d;
    qy_q          <= qy_d;
    j_q           <= j_d;
    pend_q        <= pend_d;
    out_partner_q <= out_partner_d;
    out_has_q     <= out_has_d;
    out_status_q  <= out_status_d;
    out_last_q    <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign partner_index_o = out_partner_q;
  assign has_partner_o   = out_has_q;
  assign status_o        = out_status_q;
  assign last_o          = out_last_q;

endmodule

### tb/sv/tb_far_point_pair_lister_core.sv
// Self-checking testbench for the far point pair lister core.
`timescale 1ns / 1ps

module tb_far_point_pair_lister_core;

  localparam int MAX_PTS = fplst_pkg::MAX_POINTS_DEF;
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int QUIET_LIMIT = 3000;
  localparam logic [fplst_pkg::DIST_W-1:0] DIST_MAX = 17'd80000;

  typedef struct packed {
    logic mode;
    logic [fplst_pkg::COORD_W-1:0] x;
    logic [fplst_pkg::COORD_W-1:0] y;
    logic [fplst_pkg::IDX_W-1:0] qidx;
  } point_item_t;

  typedef struct packed {
    logic [fplst_pkg::IDX_W-1:0] partner_index;
    logic has_partner;
    fplst_pkg::fplst_status_e status;
    logic last;
  } far_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic mode_i = 1'b0;
  logic signed [fplst_pkg::COORD_W-1:0] x_coord_i = '0;
  logic signed [fplst_pkg::COORD_W-1:0] y_coord_i = '0;
  logic [fplst_pkg::IDX_W-1:0] query_index_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [fplst_pkg::IDX_W-1:0] partner_index_o;
  logic has_partner_o;
  logic [1:0] status_o;
  logic last_o;
  logic cfg_we_i = 1'b0;
  logic [fplst_pkg::DIST_W-1:0] cfg_wdata_i = '0;

  point_item_t pending_items[$];
  far_result_t expected_results[$];
  int mismatch_count = 0;
  int send_idle_pct = 36;
  int recv_idle_pct = 61;
  int ready_hold_requests = 0;
  int ready_hold_served = 0;
  int ready_hold_left = 0;
  int quiet_cycles = 0;

  // Predictor state, updated as input beats are accepted.
  logic signed [fplst_pkg::COORD_W-1:0] pt_x[MAX_PTS];
  logic signed [fplst_pkg::COORD_W-1:0] pt_y[MAX_PTS];
  int stored_count = 0;
  logic drained[MAX_PTS] = '{default: 1'b0};
  logic [fplst_pkg::DIST_W-1:0] far_dist_min = '0;

  // Stimulus-side view of the store, updated as items are queued.
  int gen_count = 0;
  logic gen_drained[MAX_PTS] = '{default: 1'b0};
  int drain_budget = 0;

  far_point_pair_lister_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .mode_i(mode_i),
    .x_coord_i(x_coord_i),
    .y_coord_i(y_coord_i),
    .query_index_i(query_index_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .partner_index_o(partner_index_o),
    .has_partner_o(has_partner_o),
    .status_o(status_o),
    .last_o(last_o),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void predict_far_partners(input logic mode, input logic signed [7:0] x,
                                               input logic signed [7:0] y,
                                               input logic [fplst_pkg::IDX_W-1:0] q);
    far_result_t r;
    far_result_t partners[$];
    int dx;
    int dy;
    int j;
    r = '0;
    r.status = fplst_pkg::RES_OK;
    r.last = 1'b1;
    if (mode == MODE_LOAD) begin
      if (stored_count >= MAX_PTS) begin
        r.status = fplst_pkg::RES_FULL;
      end else begin
        pt_x[stored_count] = x;
        pt_y[stored_count] = y;
        stored_count++;
      end
      expected_results.push_back(r);
      return;
    end
    if (q >= stored_count) begin
      r.status = fplst_pkg::RES_NOT_LOADED;
      expected_results.push_back(r);
      return;
    end
    if (!drained[q]) begin
      for (j = stored_count - 1; j >= 0; j--) begin
        if (j != q) begin
          dx = int'(pt_x[q]) - int'(pt_x[j]);
          dy = int'(pt_y[q]) - int'(pt_y[j]);
          if (dx * dx + dy * dy >= int'(far_dist_min)) begin
            r.partner_index = j[fplst_pkg::IDX_W-1:0];
            r.has_partner = 1'b1;
            r.last = 1'b0;
            partners.push_back(r);
          end
        end
      end
      drained[q] = 1'b1;
    end
    if (partners.size() == 0) begin
      r = '0;
      r.status = fplst_pkg::RES_OK;
      r.last = 1'b1;
      expected_results.push_back(r);
    end else begin
      r = partners.pop_back();
      r.last = 1'b1;
      partners.push_back(r);
      foreach (partners[k]) expected_results.push_back(partners[k]);
    end
  endfunction

  function automatic logic [7:0] random_coord();
    logic [7:0] v;
    if ($urandom_range(0, 7) == 0) v = 8'($urandom);
    else v = 8'($urandom_range(0, 200) - 100);
    return v;
  endfunction

  function automatic void queue_load(input logic [7:0] x, input logic [7:0] y);
    point_item_t it;
    it.mode = MODE_LOAD;
    it.x = x;
    it.y = y;
    it.qidx = fplst_pkg::IDX_W'($urandom);
    if (gen_count < MAX_PTS) gen_count++;
    pending_items.push_back(it);
  endfunction

  function automatic void queue_query(input logic [fplst_pkg::IDX_W-1:0] q);
    point_item_t it;
    it.mode = MODE_QUERY;
    it.x = 8'($urandom);
    it.y = 8'($urandom);
    it.qidx = q;
    if (q < gen_count) gen_drained[q] = 1'b1;
    pending_items.push_back(it);
  endfunction

  function automatic void queue_random_item();
    int open_idx[$];
    int pick;
    for (int i = 0; i < gen_count; i++) if (!gen_drained[i]) open_idx.push_back(i);
    if ($urandom_range(0, 99) < 15) begin
      queue_load(random_coord(), random_coord());
    end else if (open_idx.size() > 0 && drain_budget > 0 && $urandom_range(0, 1) == 1) begin
      pick = open_idx[$urandom_range(0, open_idx.size() - 1)];
      drain_budget--;
      queue_query(fplst_pkg::IDX_W'(pick));
    end else begin
      queue_query(fplst_pkg::IDX_W'($urandom_range(0, 15)));
    end
  endfunction

  // Sampled at the falling edge, after every update of the rising edge has settled.
  task automatic wait_all_done();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  task automatic write_threshold(input logic [fplst_pkg::DIST_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    far_dist_min = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random_phase(input int n_items, input int budget, input bit long_hold);
    drain_budget = budget;
    write_threshold(fplst_pkg::DIST_W'($urandom_range(0, 30000)));
    for (int i = 0; i < n_items / 2; i++) queue_random_item();
    if (long_hold) ready_hold_requests <= ready_hold_requests + 1;
    wait_all_done();
    for (int i = n_items / 2; i < n_items; i++) queue_random_item();
    wait_all_done();
  endtask

  // Sender: holds each beat until accepted, then may idle before the next one.
  always @(posedge clk_i) begin : item_driver
    point_item_t it;
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        in_valid_i <= 1'b1;
        mode_i <= it.mode;
        x_coord_i <= it.x;
        y_coord_i <= it.y;
        query_index_i <= it.qidx;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_receiver
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (ready_hold_left > 0) begin
      ready_hold_left <= ready_hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (ready_hold_served != ready_hold_requests) begin
      ready_hold_served <= ready_hold_requests;
      ready_hold_left <= LONG_HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : beat_monitor
    far_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("Unexpected result beat: partner_index %0d, status %0d, last %0d",
               partner_index_o, status_o, last_o);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (partner_index_o !== want.partner_index) begin
          $error("partner_index: expected %0d, actual %0d", want.partner_index,
                 partner_index_o);
          mismatch_count++;
        end
        if (has_partner_o !== want.has_partner) begin
          $error("has_partner: expected %0d, actual %0d", want.has_partner, has_partner_o);
          mismatch_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          mismatch_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last_o);
          mismatch_count++;
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_far_partners(mode_i, x_coord_i, y_coord_i, query_index_i);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_threshold('0);
    queue_query(4'd0);
    queue_load(8'sd127, 8'sd127);
    queue_load(-8'sd128, -8'sd128);
    queue_load(-8'sd100, 8'sd100);
    queue_load(8'sd100, -8'sd100);
    queue_load(8'sd0, 8'sd0);
    queue_load(8'sd1, -8'sd1);
    queue_query(4'd15);
    queue_query(4'd6);
    queue_query(4'd0);
    queue_query(4'd0);
    wait_all_done();

    // The opposite corners 2 and 3 sit exactly at the DIST_MAX threshold; corners 0 and 1 lie beyond it.
    write_threshold(DIST_MAX);
    queue_query(4'd1);
    queue_query(4'd2);
    wait_all_done();

    write_threshold(17'd1);
    queue_load(8'sd0, 8'sd0);
    queue_query(4'd4);
    for (int i = 0; i < 9; i++) queue_load(random_coord(), random_coord());
    queue_load(random_coord(), random_coord());
    wait_all_done();

    run_random_phase(62, 4, 1'b1);

    send_idle_pct = 61;
    recv_idle_pct = 36;
    run_random_phase(62, 4, 1'b1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(62, MAX_PTS, 1'b0);

    repeat (40) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
src/fplst_pkg.sv
src/fplst_ctrl.sv
src/fplst_dp.sv
src/far_point_pair_lister_core.sv
tb/sv/tb_far_point_pair_lister_core.sv
